### hdl/cod_pkg.sv
// ---------------------------------------------------------------------------
// cod_pkg: shared types and constants of the clock offset drift tracker
// register indexes, reset values and the divider status bundle
// ---------------------------------------------------------------------------
package cod_pkg;

    localparam int DRIFT_FRAC_BITS_DEF = 32;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 20;

    localparam logic [7:0]  MIN_BEACON_LEN = 8'd17;
    localparam logic [7:0]  KIND_RESET     = 8'h10;
    localparam logic [19:0] INTERVAL_RESET = 20'd80000;
    localparam logic [7:0]  HOP_RESET      = 8'd3;
    localparam logic [1:0]  COUNT_MAX      = 2'd3;
    localparam logic [1:0]  COUNT_FIRST    = 2'd1;
    localparam logic [35:0] AVG_DIVISOR    = 36'd10;
    localparam logic [31:0] AVG_RECIP      = 32'hCCCCCCCD;

    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        REG_IS_ROOT      = 2'd0,
        REG_BEACON_KIND  = 2'd1,
        REG_MIN_INTERVAL = 2'd2,
        REG_MAX_HOP      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quo;
    } div_res_t;

endpackage

### hdl/cod_div.sv
// ---------------------------------------------------------------------------
// cod_div: restoring divider
// one quotient bit per cycle, sticky overflow past 32 quotient bits
// ---------------------------------------------------------------------------
module cod_div #(
    parameter int DW = 96
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DW-1:0]    dividend,
    input  logic [63:0]      divisor,
    output cod_pkg::div_res_t res
);
    import cod_pkg::*;

    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [63:0]   rem_reg;
    logic [DW-1:0] dvd_reg;
    logic [63:0]   dsr_reg;
    logic [31:0]   quo_reg;
    logic          ovf_reg;

    logic [64:0] part;
    logic [64:0] diff;
    logic        ge;

    assign part = {rem_reg, dvd_reg[DW-1]};
    assign diff = part - {1'b0, dsr_reg};
    assign ge   = (part >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[63:0] : part[63:0];
            dvd_reg <= dvd_reg << 1;
            quo_reg <= {quo_reg[30:0], ge};
            ovf_reg <= ovf_reg | quo_reg[31];
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = quo_reg;

endmodule

### hdl/cod_mul.sv
// ---------------------------------------------------------------------------
// cod_mul: registered 32 x 32 unsigned multiplier
// partial products of the reciprocal drift average and of the time correction
// ---------------------------------------------------------------------------
module cod_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    import cod_pkg::*;

    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= {32'd0, a} * {32'd0, b};
    end

    assign p = p_reg;

endmodule

### hdl/clock_offset_drift_tracker.sv
// ---------------------------------------------------------------------------
// clock_offset_drift_tracker: beacon clock offset and drift estimator
// from item acceptance to result valid: query runs the correction multiply;
// rejected or first beacon goes straight to output; a beacon inside the
// minimum interval stops after the interval check; drift update waits on the
// bit-serial divider, plus averaging once it starts; one item at a time
// synchronous active-low reset sets state, config, tracking to reset values
// ---------------------------------------------------------------------------
module clock_offset_drift_tracker #(
    parameter int DRIFT_FRAC_BITS = cod_pkg::DRIFT_FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_action,
    input  logic [7:0]                s_frame_length,
    input  logic [7:0]                s_frame_kind,
    input  logic [7:0]                s_hop_in,
    input  logic [7:0]                s_channel_in,
    input  logic signed [7:0]         s_beacon_rssi,
    input  logic [63:0]               s_remote_time_us,
    input  logic [62:0]               s_local_time_us,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [63:0]               m_network_time_us,
    output logic                      m_synced,
    output logic signed [63:0]        m_offset_out,
    output logic signed [31:0]        m_drift_out,
    output logic signed [7:0]         m_last_rssi,
    output logic                      m_relay,
    output logic [7:0]                m_relay_hop,
    output logic                      m_set_channel,
    output logic [7:0]                m_new_channel,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cod_pkg::CFG_IW-1:0] cfg_index,
    input  logic [cod_pkg::CFG_DW-1:0] cfg_data
);
    import cod_pkg::*;

    localparam int F  = DRIFT_FRAC_BITS;
    localparam int DW = 64 + F;

    typedef enum logic [12:0] {
        ST_IDLE = 13'b0000000000001,
        ST_CHK  = 13'b0000000000010,
        ST_PREP = 13'b0000000000100,
        ST_RAW  = 13'b0000000001000,
        ST_AVGP = 13'b0000000010000,
        ST_AVGS = 13'b0000000100000,
        ST_AVG  = 13'b0000001000000,
        ST_UPD  = 13'b0000010000000,
        ST_MLO  = 13'b0000100000000,
        ST_MHI  = 13'b0001000000000,
        ST_MACC = 13'b0010000000000,
        ST_CORR = 13'b0100000000000,
        ST_OUT  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic        is_root_reg;
    logic [7:0]  kind_reg;
    logic [19:0] min_int_reg;
    logic [7:0]  max_hop_reg;

    logic [63:0] offset_reg;
    logic [31:0] drift_reg;
    logic [62:0] last_sync_reg;
    logic [1:0]  count_reg;
    logic        sync_reg;
    logic [7:0]  rssi_reg;

    logic        act_reg;
    logic        ok_reg;
    logic        setch_reg;
    logic [7:0]  hop_reg;
    logic [7:0]  chan_reg;
    logic [62:0] loc_reg;
    logic [63:0] nw_reg;
    logic [63:0] dt_reg;
    logic [64:0] diff_reg;
    logic [64:0] sum_reg;
    logic [31:0] raw_reg;
    logic [35:0] s_reg;
    logic        sneg_reg;
    logic [63:0] base_reg;
    logic [31:0] dmag_reg;
    logic        dneg_reg;
    logic [95:0] acc_reg;
    logic [63:0] corr_reg;

    logic        accept;
    logic        out_load;
    logic        beacon_ok;
    logic        div_start;
    logic [DW-1:0] div_dvd;
    logic [63:0] div_dsr;
    div_res_t    div_res;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] mag;
    logic [31:0] raw_sat;
    logic [35:0] s_sum;
    logic [35:0] s_abs;
    logic [35:0] avg_ten;
    logic [35:0] avg_rem;
    logic [31:0] avg_q;
    logic [64:0] off_adj;
    logic [95:0] acc_sh;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid || m_ready);

    assign beacon_ok = (s_frame_length >= MIN_BEACON_LEN) && (s_frame_kind == kind_reg)
                       && !is_root_reg;

    assign mag = diff_reg[64] ? 64'(-diff_reg) : diff_reg[63:0];

    always_comb begin
        if (div_res.ovf || (diff_reg[64] ? (div_res.quo > 32'h80000000) : div_res.quo[31]))
        begin
            raw_sat = diff_reg[64] ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            raw_sat = diff_reg[64] ? -div_res.quo : div_res.quo;
        end
    end

    assign s_sum = ({{4{drift_reg[31]}}, drift_reg} <<< 3) - {{4{drift_reg[31]}}, drift_reg}
                 + ({{4{raw_reg[31]}}, raw_reg} <<< 1) + {{4{raw_reg[31]}}, raw_reg};
    assign s_abs = s_reg[35] ? -s_reg : s_reg;

    // quotient estimate from the reciprocal product, at most one short
    assign avg_ten = ({4'd0, mul_p[63:32]} << 3) + ({4'd0, mul_p[63:32]} << 1);
    assign avg_rem = s_abs - avg_ten;
    assign avg_q   = mul_p[63:32] + {31'd0, (avg_rem >= AVG_DIVISOR)};

    assign off_adj = sum_reg + {64'd0, sum_reg[64] & sum_reg[0]};
    assign acc_sh  = acc_reg >> F;

    always_comb begin
        div_start = 1'b0;
        div_dvd   = DW'(mag) << F;
        div_dsr   = dt_reg;
        case (state_reg)
            ST_PREP: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign mul_a = (state_reg == ST_AVGS) ? s_abs[34:3] : dmag_reg;
    assign mul_b = (state_reg == ST_MHI) ? dt_reg[63:32]
                 : (state_reg == ST_AVGS) ? AVG_RECIP : dt_reg[31:0];

    cod_div #(.DW(DW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .res      (div_res)
    );

    cod_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_action == ACT_QUERY) begin
                        state_next = ST_MLO;
                    end else if (beacon_ok && sync_reg) begin
                        state_next = ST_CHK;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_CHK: begin
                if (!dt_reg[63] && (dt_reg > {44'd0, min_int_reg})) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_PREP: state_next = ST_RAW;
            ST_RAW: begin
                if (div_res.done) begin
                    state_next = (count_reg == COUNT_MAX) ? ST_AVGP : ST_UPD;
                end
            end
            ST_AVGP: state_next = ST_AVGS;
            ST_AVGS: state_next = ST_AVG;
            ST_AVG:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_OUT;
            ST_MLO:  state_next = ST_MHI;
            ST_MHI:  state_next = ST_MACC;
            ST_MACC: state_next = ST_CORR;
            ST_CORR: state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid       <= 1'b0;
            is_root_reg   <= 1'b0;
            kind_reg      <= KIND_RESET;
            min_int_reg   <= INTERVAL_RESET;
            max_hop_reg   <= HOP_RESET;
            offset_reg    <= '0;
            drift_reg     <= '0;
            last_sync_reg <= '0;
            count_reg     <= '0;
            sync_reg      <= 1'b0;
            rssi_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept && s_action != ACT_QUERY && beacon_ok) begin
                        rssi_reg <= s_beacon_rssi;
                        if (!sync_reg) begin
                            offset_reg    <= s_remote_time_us - {1'b0, s_local_time_us};
                            last_sync_reg <= s_local_time_us;
                            count_reg     <= COUNT_FIRST;
                            sync_reg      <= 1'b1;
                        end
                    end
                end
                ST_RAW: begin
                    if (div_res.done && count_reg != COUNT_MAX) begin
                        drift_reg <= raw_sat;
                    end
                end
                ST_AVG: begin
                    drift_reg <= sneg_reg ? -avg_q : avg_q;
                end
                ST_UPD: begin
                    offset_reg    <= off_adj[64:1];
                    last_sync_reg <= loc_reg;
                    if (count_reg != COUNT_MAX) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_IS_ROOT: begin
                        is_root_reg <= cfg_data[0];
                        if (cfg_data[0]) begin
                            sync_reg   <= 1'b1;
                            offset_reg <= '0;
                            drift_reg  <= '0;
                        end
                    end
                    REG_BEACON_KIND:  kind_reg    <= cfg_data[7:0];
                    REG_MIN_INTERVAL: min_int_reg <= cfg_data[19:0];
                    REG_MAX_HOP:      max_hop_reg <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    act_reg   <= s_action;
                    ok_reg    <= (s_action != ACT_QUERY) && beacon_ok;
                    setch_reg <= (s_action != ACT_QUERY) && beacon_ok && !sync_reg;
                    hop_reg   <= s_hop_in;
                    chan_reg  <= s_channel_in;
                    loc_reg   <= s_local_time_us;
                    nw_reg    <= s_remote_time_us - {1'b0, s_local_time_us};
                    dt_reg    <= {1'b0, s_local_time_us} - {1'b0, last_sync_reg};
                    base_reg  <= {1'b0, s_local_time_us} + offset_reg;
                    dmag_reg  <= drift_reg[31] ? -drift_reg : drift_reg;
                    dneg_reg  <= drift_reg[31];
                end
            end
            ST_CHK: begin
                diff_reg <= {nw_reg[63], nw_reg} - {offset_reg[63], offset_reg};
                sum_reg  <= {nw_reg[63], nw_reg} + {offset_reg[63], offset_reg};
            end
            ST_RAW: begin
                if (div_res.done) begin
                    raw_reg <= raw_sat;
                end
            end
            ST_AVGP: begin
                s_reg <= s_sum;
            end
            ST_AVGS: begin
                sneg_reg <= s_reg[35];
            end
            ST_MHI: begin
                acc_reg <= {32'd0, mul_p};
            end
            ST_MACC: begin
                acc_reg <= acc_reg + {mul_p, 32'd0};
            end
            ST_CORR: begin
                corr_reg <= dneg_reg ? -acc_sh[63:0] : acc_sh[63:0];
            end
            default: begin
            end
        endcase

        if (out_load) begin
            m_network_time_us <= (act_reg == ACT_QUERY) ? base_reg + corr_reg : 64'd0;
            m_synced          <= sync_reg;
            m_offset_out      <= offset_reg;
            m_drift_out       <= drift_reg;
            m_last_rssi       <= rssi_reg;
            m_relay           <= ok_reg && sync_reg && (hop_reg < max_hop_reg);
            m_relay_hop       <= (ok_reg && sync_reg && (hop_reg < max_hop_reg))
                                 ? hop_reg + 8'd1 : 8'd0;
            m_set_channel     <= setch_reg;
            m_new_channel     <= setch_reg ? chan_reg : 8'd0;
        end
    end

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_RAW))
        else $error("divider finished outside a wait state");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while busy");

    a_setch_synced: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_set_channel) |-> m_synced)
        else $error("channel switch without sync");

    a_relay_synced: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_relay) |-> (m_synced && m_network_time_us == 64'd0))
        else $error("relay on unsynced node or on a query");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid && !m_ready) |=> state_reg == ST_OUT)
        else $error("result dropped while output stalled");

endmodule
